### sv/esec_pkg.sv
// shared types and constants for the effective storativity secant core
package esec_pkg;

    localparam int ONE_Q16    = 65536;
    localparam int ROOT_BITS  = 32;
    localparam int QUOT_BITS  = 17;
    localparam int POR_W      = 17;
    localparam int DEPTH_W    = 32;
    localparam int SUM_MAG_W  = 33;
    localparam int RAD_W      = 64;
    localparam int DIVD_W     = SUM_MAG_W + 16;

    localparam logic REG_SMOOTHING_WIDTH = 1'b0;
    localparam logic REG_EXTENDED_MODE   = 1'b1;

    localparam logic [16:0] RESET_SMOOTHING_WIDTH = 17'd655;

    typedef struct packed {
        logic signed [DEPTH_W-1:0] old_depth;
        logic signed [DEPTH_W-1:0] new_depth;
        logic        [POR_W-1:0]   porosity;
    } in_item_t;

    typedef struct packed {
        logic [POR_W-1:0] storativity;
        logic             used_tangent;
    } out_item_t;

    // per-item values that ride alongside the root and divide pipelines
    typedef struct packed {
        logic [SUM_MAG_W-1:0] sum_mag;
        logic                 sum_neg;
        logic [POR_W-1:0]     por;
        logic                 tangent;
        logic                 den_zero;
    } side_t;

endpackage

### sv/esec_isqrt.sv
// two-lane pipelined integer square root, one result bit per stage
module esec_isqrt (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [1:0][esec_pkg::RAD_W-1:0]   in_rad,
    input  esec_pkg::side_t                   in_side,
    output logic                              out_valid,
    output logic [1:0][esec_pkg::ROOT_BITS-1:0] out_root,
    output esec_pkg::side_t                   out_side
);

    localparam int STAGES = esec_pkg::ROOT_BITS;
    localparam int W      = esec_pkg::RAD_W;

    logic [STAGES-1:0]     vld_reg;
    logic [1:0][W-1:0]     rem_reg  [0:STAGES-1];
    logic [1:0][W-1:0]     res_reg  [0:STAGES-1];
    esec_pkg::side_t       side_reg [0:STAGES-1];

    genvar g;
    generate
        for (g = 0; g < STAGES; g++) begin : g_stage
            localparam logic [W-1:0] BIT = W'(1) << (2 * (STAGES - 1 - g));
            logic [1:0][W-1:0] rem_in, res_in, rem_next, res_next;
            esec_pkg::side_t   side_in;
            logic              vld_in;

            if (g == 0) begin : g_first
                assign rem_in  = in_rad;
                assign res_in  = '0;
                assign side_in = in_side;
                assign vld_in  = in_valid;
            end else begin : g_rest
                assign rem_in  = rem_reg[g-1];
                assign res_in  = res_reg[g-1];
                assign side_in = side_reg[g-1];
                assign vld_in  = vld_reg[g-1];
            end

            always_comb begin
                logic [W:0] trial;
                for (int l = 0; l < 2; l++) begin
                    trial = {1'b0, res_in[l]} + {1'b0, BIT};
                    if ({1'b0, rem_in[l]} >= trial) begin
                        rem_next[l] = rem_in[l] - trial[W-1:0];
                        res_next[l] = (res_in[l] >> 1) + BIT;
                    end else begin
                        rem_next[l] = rem_in[l];
                        res_next[l] = res_in[l] >> 1;
                    end
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[g] <= 1'b0;
                end else if (en) begin
                    vld_reg[g] <= vld_in;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[g]  <= rem_next;
                    res_reg[g]  <= res_next;
                    side_reg[g] <= side_in;
                end
            end
        end
    endgenerate

    assign out_valid   = vld_reg[STAGES-1];
    assign out_root[0] = res_reg[STAGES-1][0][STAGES-1:0];
    assign out_root[1] = res_reg[STAGES-1][1][STAGES-1:0];
    assign out_side    = side_reg[STAGES-1];

endmodule

### sv/esec_div.sv
// pipelined restoring divider, one quotient bit per stage
module esec_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [esec_pkg::SUM_MAG_W-1:0]    in_den,
    input  esec_pkg::side_t                   in_side,
    output logic                              out_valid,
    output logic [esec_pkg::QUOT_BITS-1:0]    out_quot,
    output esec_pkg::side_t                   out_side
);

    localparam int STAGES = esec_pkg::QUOT_BITS;
    localparam int RW     = esec_pkg::DIVD_W + 1;
    localparam int DW     = esec_pkg::SUM_MAG_W;

    logic [STAGES-1:0]  vld_reg;
    logic [RW-1:0]      rem_reg  [0:STAGES-1];
    logic [STAGES-1:0]  quot_reg [0:STAGES-1];
    logic [DW-1:0]      den_reg  [0:STAGES-1];
    esec_pkg::side_t    side_reg [0:STAGES-1];

    genvar g;
    generate
        for (g = 0; g < STAGES; g++) begin : g_stage
            localparam int K = STAGES - 1 - g;
            logic [RW-1:0]     rem_in, rem_next, trial;
            logic [STAGES-1:0] quot_in, quot_next;
            logic [DW-1:0]     den_in;
            esec_pkg::side_t   side_in;
            logic              vld_in;

            if (g == 0) begin : g_first
                assign rem_in  = {1'b0, in_side.sum_mag, 16'd0};
                assign quot_in = '0;
                assign den_in  = in_den;
                assign side_in = in_side;
                assign vld_in  = in_valid;
            end else begin : g_rest
                assign rem_in  = rem_reg[g-1];
                assign quot_in = quot_reg[g-1];
                assign den_in  = den_reg[g-1];
                assign side_in = side_reg[g-1];
                assign vld_in  = vld_reg[g-1];
            end

            assign trial = RW'(den_in) << K;

            always_comb begin
                quot_next = quot_in;
                if (rem_in >= trial) begin
                    rem_next     = rem_in - trial;
                    quot_next[K] = 1'b1;
                end else begin
                    rem_next = rem_in;
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[g] <= 1'b0;
                end else if (en) begin
                    vld_reg[g] <= vld_in;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[g]  <= rem_next;
                    quot_reg[g] <= quot_next;
                    den_reg[g]  <= den_in;
                    side_reg[g] <= side_in;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[STAGES-1];
    assign out_quot  = quot_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];

endmodule

### sv/effective_storativity_secant_core.sv
// top level of the effective storativity secant core
// Streams one grid cell per clock when not stalled: each transfer carries an old and a
// new water-table depth and a porosity, and returns one storativity in Q1.16 (saturated
// to 0..1.0) and a flag set when the depths were equal and the tangent slope was used.
// The secant is 0.5*((1+p)+(1-p)*(n+o)/(R(n)+R(o))) with R(w) = floor(sqrt(w^2+eps^2));
// extended-soil mode returns the clamped porosity and a clear flag. Items pass the input
// and square registers, the 32-stage square root pipeline, the sum register, the 17-stage
// quotient pipeline and the multiply and output registers. A result-side stall freezes
// the whole pipeline, so nothing is lost or repeated. eps and extended-soil mode are set
// through the APB port (byte address 0 and 4) and should only change while idle.
module effective_storativity_secant_core (
    input  logic                aclk,
    input  logic                aresetn,
    // input stream
    input  logic                s_valid,
    output logic                s_ready,
    input  esec_pkg::in_item_t  s_data,
    // result stream
    output logic                m_valid,
    input  logic                m_ready,
    output esec_pkg::out_item_t m_data,
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int SMW = esec_pkg::SUM_MAG_W;
    localparam int PW  = esec_pkg::POR_W;

    // config registers
    logic [16:0] eps_reg;
    logic        ext_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg <= esec_pkg::RESET_SMOOTHING_WIDTH;
            ext_reg <= 1'b0;
        end else if (cfg_wr) begin
            if (paddr[2] == esec_pkg::REG_SMOOTHING_WIDTH) begin
                eps_reg <= pwdata[16:0];
            end else begin
                ext_reg <= pwdata[0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == esec_pkg::REG_EXTENDED_MODE) begin
            prdata = {31'd0, ext_reg};
        end else begin
            prdata = {15'd0, eps_reg};
        end
    end

    // global pipeline advance: move whenever the output slot is free or being taken
    logic en;
    logic out_vld_reg;
    assign en      = !out_vld_reg || m_ready;
    assign s_ready = en;

    // stage 1: magnitudes, depth sum, clamped porosity, equality
    logic             s1_vld_reg;
    logic [31:0]      s1_mag_n_reg, s1_mag_o_reg;
    esec_pkg::side_t  s1_side_reg;
    logic signed [32:0] in_sum;
    logic [PW-1:0]    in_por;

    assign in_sum = 33'(s_data.new_depth) + 33'(s_data.old_depth);
    assign in_por = (s_data.porosity > PW'(esec_pkg::ONE_Q16)) ?
                    PW'(esec_pkg::ONE_Q16) : s_data.porosity;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (en) begin
            s1_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_mag_n_reg <= s_data.new_depth[31] ? 32'(-s_data.new_depth)
                                                 : 32'(s_data.new_depth);
            s1_mag_o_reg <= s_data.old_depth[31] ? 32'(-s_data.old_depth)
                                                 : 32'(s_data.old_depth);
            s1_side_reg.sum_mag  <= in_sum[32] ? SMW'(-in_sum) : SMW'(in_sum);
            s1_side_reg.sum_neg  <= in_sum[32];
            s1_side_reg.por      <= in_por;
            s1_side_reg.tangent  <= (s_data.new_depth == s_data.old_depth);
            s1_side_reg.den_zero <= 1'b0;
        end
    end

    // stage 2: w^2 + eps^2 for both depths
    logic                            s2_vld_reg;
    logic [1:0][esec_pkg::RAD_W-1:0] s2_rad_reg;
    esec_pkg::side_t                 s2_side_reg;
    logic [33:0]                     eps_sq;

    assign eps_sq = 34'(eps_reg) * 34'(eps_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_vld_reg <= 1'b0;
        end else if (en) begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_rad_reg[0] <= 64'(s1_mag_n_reg) * 64'(s1_mag_n_reg) + 64'(eps_sq);
            s2_rad_reg[1] <= 64'(s1_mag_o_reg) * 64'(s1_mag_o_reg) + 64'(eps_sq);
            s2_side_reg   <= s1_side_reg;
        end
    end

    // square roots
    logic                                rt_vld;
    logic [1:0][esec_pkg::ROOT_BITS-1:0] rt_root;
    esec_pkg::side_t                     rt_side;

    esec_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s2_vld_reg),
        .in_rad    (s2_rad_reg),
        .in_side   (s2_side_reg),
        .out_valid (rt_vld),
        .out_root  (rt_root),
        .out_side  (rt_side)
    );

    // denominator R(n) + R(o)
    logic             dn_vld_reg;
    logic [SMW-1:0]   dn_den_reg;
    esec_pkg::side_t  dn_side_reg;
    esec_pkg::side_t  dn_side_next;
    logic [SMW-1:0]   den_sum;

    assign den_sum = SMW'(rt_root[0]) + SMW'(rt_root[1]);

    // flag a zero denominator so the quotient can be forced to zero
    always_comb begin
        dn_side_next          = rt_side;
        dn_side_next.den_zero = (den_sum == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dn_vld_reg <= 1'b0;
        end else if (en) begin
            dn_vld_reg <= rt_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dn_den_reg  <= den_sum;
            dn_side_reg <= dn_side_next;
        end
    end

    // quotient |n+o| * 2^16 / den, never above 1.0 since den >= |n+o|
    logic                           dv_vld;
    logic [esec_pkg::QUOT_BITS-1:0] dv_quot;
    esec_pkg::side_t                dv_side;

    esec_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (dn_vld_reg),
        .in_den    (dn_den_reg),
        .in_side   (dn_side_reg),
        .out_valid (dv_vld),
        .out_quot  (dv_quot),
        .out_side  (dv_side)
    );

    // multiply stage: (1-p)*q and (1+p) in Q3.32, the product signed
    logic               mu_vld_reg;
    logic signed [35:0] mu_prod_reg;
    logic [34:0]        mu_base_reg;
    logic [PW-1:0]      mu_por_reg;
    logic               mu_tan_reg;
    logic [16:0]        q_mag;
    logic signed [17:0] q_s;
    logic signed [17:0] one_minus_p;

    assign q_mag = dv_side.den_zero ? 17'd0
                 : ((dv_quot > 17'(esec_pkg::ONE_Q16)) ? 17'(esec_pkg::ONE_Q16) : dv_quot);
    assign q_s   = dv_side.sum_neg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
    assign one_minus_p = $signed(18'(esec_pkg::ONE_Q16) - 18'(dv_side.por));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mu_vld_reg <= 1'b0;
        end else if (en) begin
            mu_vld_reg <= dv_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mu_prod_reg <= 36'(one_minus_p) * 36'(q_s);
            mu_base_reg <= {18'(esec_pkg::ONE_Q16) + 18'(dv_side.por), 17'd0} >> 1;
            mu_por_reg  <= dv_side.por;
            mu_tan_reg  <= dv_side.tangent;
        end
    end

    // output stage: halve with rounding, saturate, mode select
    esec_pkg::out_item_t out_data_reg;
    logic signed [36:0]  x_sum;
    logic [36:0]         x_pos;
    logic [36:0]         x_half;
    logic [PW-1:0]       sto;

    assign x_sum  = 37'(mu_prod_reg) + $signed({2'b00, mu_base_reg});
    assign x_pos  = x_sum[36] ? 37'd0 : x_sum;
    assign x_half = (x_pos + 37'(esec_pkg::ONE_Q16)) >> 17;
    assign sto    = (x_half > 37'(esec_pkg::ONE_Q16)) ? PW'(esec_pkg::ONE_Q16)
                                                       : x_half[PW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= mu_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (ext_reg) begin
                out_data_reg.storativity  <= mu_por_reg;
                out_data_reg.used_tangent <= 1'b0;
            end else begin
                out_data_reg.storativity  <= sto;
                out_data_reg.used_tangent <= mu_tan_reg;
            end
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_data_reg;

endmodule

### tb/tb_effective_storativity_secant_core.sv
// testbench for the effective storativity secant core with a scoreboard
module tb_effective_storativity_secant_core;

    // register byte addresses on the config port
    localparam logic [2:0] ADDR_WIDTH = 3'd0;
    localparam logic [2:0] ADDR_MODE  = 3'd4;
    localparam int LATENCY = 54;
    localparam int N_RANDOM = 1400;

    // integer square root, floor, on a 64-bit value
    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'h4000_0000_0000_0000;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // expected storativity for one cell under the given width and mode
    function automatic esec_pkg::out_item_t storativity_of(esec_pkg::in_item_t c,
                                                           logic [16:0] eps, logic ext);
        esec_pkg::out_item_t r;
        longint o, n, sum, q, x;
        longint unsigned p, mo, mn, den, num, s, sum_mag;
        o = longint'(c.old_depth);
        n = longint'(c.new_depth);
        p = c.porosity;
        if (p > esec_pkg::ONE_Q16) p = esec_pkg::ONE_Q16;
        if (ext) begin
            r.storativity = p[16:0];
            r.used_tangent = 1'b0;
            return r;
        end
        mo = o < 0 ? -o : o;
        mn = n < 0 ? -n : n;
        den = floor_root(mn * mn + 64'(eps) * 64'(eps))
            + floor_root(mo * mo + 64'(eps) * 64'(eps));
        sum = n + o;
        if (den == 0) begin
            q = 0;
        end else begin
            sum_mag = sum < 0 ? -sum : sum;
            num = (sum_mag << 16) / den;
            if (num > esec_pkg::ONE_Q16) num = esec_pkg::ONE_Q16;
            q = sum < 0 ? -longint'(num) : longint'(num);
        end
        x = longint'(esec_pkg::ONE_Q16 + p) * esec_pkg::ONE_Q16
          + longint'(esec_pkg::ONE_Q16 - p) * q;
        if (x < 0) x = 0;
        s = x;
        s = (s + esec_pkg::ONE_Q16) >> 17;
        if (s > esec_pkg::ONE_Q16) s = esec_pkg::ONE_Q16;
        r.storativity = s[16:0];
        r.used_tangent = (n == o);
        return r;
    endfunction

    class storativity_board;
        esec_pkg::out_item_t pending[$];
        int errors;
        int checked;
        logic [16:0] eps = esec_pkg::RESET_SMOOTHING_WIDTH;
        logic ext = 1'b0;

        function void note_cell(esec_pkg::in_item_t c);
            pending.push_back(storativity_of(c, eps, ext));
        endfunction

        function void check_result(esec_pkg::out_item_t got);
            esec_pkg::out_item_t want;
            if (pending.size() == 0) begin
                $error("result with nothing pending: storativity %0d", got.storativity);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.storativity !== want.storativity) begin
                $error("storativity expected %0d actual %0d",
                       want.storativity, got.storativity);
                errors++;
            end
            if (got.used_tangent !== want.used_tangent) begin
                $error("used_tangent expected %0d actual %0d",
                       want.used_tangent, got.used_tangent);
                errors++;
            end
        endfunction
    endclass

    logic aclk, aresetn;
    logic s_valid, s_ready, m_valid, m_ready;
    esec_pkg::in_item_t s_data;
    esec_pkg::out_item_t m_data;
    logic psel, penable, pwrite, pready;
    logic [2:0] paddr;
    logic [31:0] pwdata, prdata;

    storativity_board board;
    int tangent_seen;

    effective_storativity_secant_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // hard stop, far past the slowest legal run
    initial begin
        #5000000;
        $display("effective_storativity_secant_core: mismatch");
        $finish;
    end

    // register write: setup phase then access phase, then the bus goes idle
    task automatic reg_write(logic [2:0] addr, logic [31:0] value);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= addr; pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == ADDR_WIDTH) board.eps = value[16:0];
        else board.ext = value[0];
        @(posedge aclk);
    endtask

    // one input transfer after a random gap; valid held until accepted
    task automatic send_cell(esec_pkg::in_item_t c, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_cell(c);
    endtask

    // pause the sender until everything in flight has returned
    task automatic drain();
        s_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (LATENCY + 5) @(posedge aclk);
    endtask

    function automatic esec_pkg::in_item_t random_cell();
        esec_pkg::in_item_t c;
        int kind;
        kind = $urandom_range(0, 9);
        c.old_depth = $urandom;
        c.porosity = $urandom_range(0, 9) == 0 ? 17'($urandom) : 17'($urandom_range(0, 65536));
        case (kind)
            0, 1: c.new_depth = c.old_depth;
            2, 3, 4: begin
                // shallow depths near the surface, where the smoothing matters
                c.old_depth = $signed($urandom_range(0, 262144)) - 131072;
                c.new_depth = $signed($urandom_range(0, 262144)) - 131072;
            end
            5: c.new_depth = c.old_depth + $signed($urandom_range(0, 200)) - 100;
            6: c.new_depth = -c.old_depth;
            default: c.new_depth = $urandom;
        endcase
        return c;
    endfunction

    // result side: random stalls, with some stall-free stretches
    initial begin
        int hold;
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            if (hold != 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            board.check_result(m_data);
            if (m_data.used_tangent) tangent_seen++;
        end
    end

    initial begin
        esec_pkg::in_item_t c;
        int waited;
        logic [31:0] width_set[4];
        board = new();
        tangent_seen = 0;
        s_valid = 1'b0; s_data = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        aresetn = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, equal depths, zero width at zero depth, porosity above one
        reg_write(ADDR_WIDTH, 32'd0);
        reg_write(ADDR_MODE, 32'd0);
        send_cell('{0, 0, 17'd30000}, 0);
        send_cell('{32'sh8000_0000, 32'sh7fff_ffff, 17'd0}, 0);
        send_cell('{32'sh7fff_ffff, 32'sh8000_0000, 17'd65536}, 0);
        send_cell('{32'sh7fff_ffff, 32'sh7fff_ffff, 17'h1ffff}, 0);
        send_cell('{32'sh8000_0000, 32'sh8000_0000, 17'd65537}, 0);
        send_cell('{32'sh0001_0000, -32'sh0001_0000, 17'd40000}, 0);
        drain();
        reg_write(ADDR_WIDTH, 32'd65536);
        send_cell('{0, 0, 17'd0}, 0);
        send_cell('{1, 0, 17'd65536}, 0);
        send_cell('{-1, -1, 17'd12345}, 0);
        send_cell('{32'sh7fff_ffff, -32'sh7fff_ffff, 17'd100}, 0);
        send_cell('{32'sh8000_0000, 32'sh0000_0001, 17'h1ffff}, 0);
        drain();
        reg_write(ADDR_MODE, 32'd1);
        send_cell('{5, 5, 17'd20000}, 0);
        send_cell('{3, 9, 17'h1ffff}, 0);
        send_cell('{-3, 9, 17'd65536}, 0);
        drain();

        // random phases over several widths and both modes
        width_set[0] = 32'd655;
        width_set[1] = 32'd1;
        width_set[2] = 32'd65536;
        width_set[3] = {$urandom} | 32'h1_ffff;
        for (int ph = 0; ph < 8; ph++) begin
            reg_write(ADDR_WIDTH, ph == 7 ? 32'd1 + ($urandom % 65536) : width_set[ph % 4]);
            reg_write(ADDR_MODE, (ph == 5) ? 32'd1 : 32'd0);
            for (int i = 0; i < N_RANDOM / 8; i++) begin
                c = random_cell();
                send_cell(c, (ph % 3) == 0 && (i % 50) < 20);
            end
            drain();
        end

        waited = 0;
        while (board.pending.size() != 0 && waited < 200000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (LATENCY + 10) @(posedge aclk);
        $display("covered %0d results (%0d on the tangent path)",
                 board.checked, tangent_seen);
        $display("over several widths, both modes, stalls and back-to-back bursts");
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("effective_storativity_secant_core: match");
        end else begin
            $display("effective_storativity_secant_core: mismatch");
        end
        $finish;
    end
endmodule
